// File: rtl/core/assert_macros.svh
// Assertion macros shared by the console core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TCW_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TCW_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/tcw_pkg.sv
// Package with sizes, character codes, opcodes and control types of the text console.
package tcw_pkg;

   // Screen geometry.
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;
   localparam int COPY_N  = CELLS - COLUMNS;

   // Field and address widths.
   localparam int CHAR_W = 8;
   localparam int OP_W   = 2;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int ADDR_W = $clog2(CELLS);

   // Character codes with special meaning.
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

   // Item opcodes; the fourth code does nothing.
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // Controller states.
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_FILL,
      ST_CLEAR,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic cursor_upd;
      logic copy_step;
      logic blank_step;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            will_scroll;
      logic            scroll_flag;
      logic            copy_last;
      logic            blank_last;
      logic            rsp_free;
   } status_type;

endpackage

// File: rtl/core/tcw_datapath.sv
// Datapath of the text console: item registers, cursor, screen memory and result register.
`include "assert_macros.svh"

module tcw_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  tcw_pkg::cmd_type            cmd,
   output tcw_pkg::status_type         status,
   input  logic [tcw_pkg::OP_W-1:0]    req_opcode,
   input  logic [tcw_pkg::CHAR_W-1:0]  req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]   req_read_row,
   input  logic [tcw_pkg::COL_W-1:0]   req_read_col,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tcw_pkg::CHAR_W-1:0]  rsp_cell_char,
   output logic [tcw_pkg::COL_W-1:0]   rsp_cursor_col,
   output logic [tcw_pkg::ROW_W-1:0]   rsp_cursor_row,
   output logic                        rsp_scrolled
);
   import tcw_pkg::*;

   // Screen memory.
   logic [CHAR_W-1:0] mem [CELLS];

   logic [OP_W-1:0]   op_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [ROW_W-1:0]  rrow_ff;
   logic [COL_W-1:0]  rcol_ff;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              scroll_ff, scroll_in;
   logic [CHAR_W-1:0] rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] cell_ff;
   logic [COL_W-1:0]  rcol_out_ff;
   logic [ROW_W-1:0]  rrow_out_ff;
   logic              rscroll_ff;

   logic [COL_W:0]    col_step;
   logic [ROW_W:0]    row_step;
   logic              store_en;
   logic              will_scroll;
   logic [COL_W-1:0]  col_nx;
   logic [ROW_W-1:0]  row_nx;
   logic [ADDR_W-1:0] cursor_addr;
   logic [ADDR_W-1:0] item_addr;
   logic              in_range;
   logic              copy_last;
   logic              blank_last;
   logic [ADDR_W-1:0] raddr;
   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic [CHAR_W-1:0] wdata;
   logic              rsp_free;

   // Cursor movement for a written character, including wrap and scroll detection.
   always_comb begin
      col_step = {1'b0, col_ff};
      row_step = {1'b0, row_ff};
      store_en = 1'b0;
      if (char_ff == CH_NEWLINE) begin
         col_step = '0;
         row_step = row_step + 1'b1;
      end else if (char_ff == CH_RETURN) begin
         col_step = '0;
      end else begin
         store_en = 1'b1;
         col_step = col_step + 1'b1;
      end
      if (col_step >= (COL_W+1)'(COLUMNS)) begin
         col_step = '0;
         row_step = row_step + 1'b1;
      end
      will_scroll = (row_step >= (ROW_W+1)'(ROWS));
      col_nx      = col_step[COL_W-1:0];
      row_nx      = will_scroll ? ROW_W'(ROWS - 1) : row_step[ROW_W-1:0];
   end

   // Cell addresses of the cursor and of the requested cell.
   assign cursor_addr = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff));
   assign in_range    = ({1'b0, rrow_ff} < (ROW_W+1)'(ROWS)) &&
                        ({1'b0, rcol_ff} < (COL_W+1)'(COLUMNS));
   assign item_addr   = in_range ?
                        ADDR_W'(ADDR_W'(rrow_ff) * ADDR_W'(COLUMNS) + ADDR_W'(rcol_ff)) : '0;

   assign copy_last  = (sweep_ff == ADDR_W'(COPY_N));
   assign blank_last = (sweep_ff == ADDR_W'(CELLS - 1));

   // Read address: the source row during a scroll, otherwise the requested cell.
   always_comb begin
      if (cmd.copy_step && !copy_last) begin
         raddr = ADDR_W'(sweep_ff + ADDR_W'(COLUMNS));
      end else begin
         raddr = item_addr;
      end
   end

   // Write port selection: character store, scroll copy or blanking.
   always_comb begin
      we    = 1'b0;
      waddr = cursor_addr;
      wdata = char_ff;
      if (cmd.cursor_upd && store_en) begin
         we = 1'b1;
      end else if (cmd.copy_step && (sweep_ff != '0)) begin
         we    = 1'b1;
         waddr = ADDR_W'(sweep_ff - 1'b1);
         wdata = rd_data_ff;
      end else if (cmd.blank_step) begin
         we    = 1'b1;
         waddr = sweep_ff;
         wdata = CH_SPACE;
      end
   end

   // Screen memory ports.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[raddr];
   end

   // Next values of cursor, sweep counter and scroll flag.
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      sweep_in  = sweep_ff;
      scroll_in = scroll_ff;
      if (cmd.capture) begin
         sweep_in  = '0;
         scroll_in = 1'b0;
      end
      if (cmd.cursor_upd) begin
         col_in    = col_nx;
         row_in    = row_nx;
         scroll_in = will_scroll;
      end
      if (cmd.copy_step) begin
         sweep_in = copy_last ? sweep_ff : ADDR_W'(sweep_ff + 1'b1);
      end
      if (cmd.blank_step) begin
         sweep_in = ADDR_W'(sweep_ff + 1'b1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         sweep_ff  <= '0;
         scroll_ff <= 1'b0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         sweep_ff  <= sweep_in;
         scroll_ff <= scroll_in;
      end
   end

   // Item registers, loaded when an input transfer takes place.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         char_ff <= req_char_code;
         rrow_ff <= req_read_row;
         rcol_ff <= req_read_col;
      end
   end

   // Result register; it frees as soon as the current result transfer completes.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         cell_ff     <= ((op_ff == OP_READ) && in_range) ? rd_data_ff : '0;
         rcol_out_ff <= col_ff;
         rrow_out_ff <= row_ff;
         rscroll_ff  <= scroll_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = cell_ff;
   assign rsp_cursor_col = rcol_out_ff;
   assign rsp_cursor_row = rrow_out_ff;
   assign rsp_scrolled   = rscroll_ff;

   // Status to the controller.
   assign status.opcode      = op_ff;
   assign status.will_scroll = will_scroll;
   assign status.scroll_flag = scroll_ff;
   assign status.copy_last   = copy_last;
   assign status.blank_last  = blank_last;
   assign status.rsp_free    = rsp_free;

   // The cursor always stays on the screen.
   `TCW_ASSERT_IMP(a_col_range, 1'b1, {1'b0, col_ff} < (COL_W+1)'(COLUMNS), "cursor column off screen")
   `TCW_ASSERT_IMP(a_row_range, 1'b1, {1'b0, row_ff} < (ROW_W+1)'(ROWS), "cursor row off screen")
   // A result is never loaded over one that is still waiting.
   `TCW_ASSERT_IMP(a_rsp_free, cmd.rsp_load, !rsp_valid_ff || rsp_ready, "result overwritten")

endmodule

// File: rtl/core/tcw_controller.sv
// Controller state machine of the text console.
`include "assert_macros.svh"

module tcw_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tcw_pkg::status_type status,
   output tcw_pkg::cmd_type    cmd
);
   import tcw_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_valid && req_ready;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (status.blank_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (status.opcode)
               OP_WRITE: state_in = status.will_scroll ? ST_SCROLL : ST_DONE;
               OP_CLEAR: state_in = ST_CLEAR;
               default:  state_in = ST_DONE;
            endcase
         end
         ST_SCROLL: begin
            if (status.copy_last) state_in = ST_FILL;
         end
         ST_FILL: begin
            if (status.blank_last) state_in = ST_DONE;
         end
         ST_CLEAR: begin
            if (status.blank_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.blank_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.cursor_upd = (status.opcode == OP_WRITE);
         end
         ST_SCROLL: begin
            cmd.copy_step = 1'b1;
         end
         ST_FILL, ST_CLEAR: begin
            cmd.blank_step = 1'b1;
         end
         ST_DONE: begin
            cmd.rsp_load = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // An accepted item is worked on in the next cycle.
   `TCW_ASSERT_NXT(a_accept_exec, accept, state_ff == ST_EXEC, "accepted item not executed")
   // Scrolling happens only for an item that moved the cursor past the last row.
   `TCW_ASSERT_IMP(a_scroll_flag, state_ff == ST_SCROLL || state_ff == ST_FILL, status.scroll_flag,
                   "scroll without scroll flag")
   // After a result is loaded the block is ready for the next item.
   `TCW_ASSERT_NXT(a_load_idle, cmd.rsp_load, state_ff == ST_IDLE, "no return to idle after result")

endmodule

// File: rtl/core/text_console_writer_core.sv
// A write or read is accepted, executed and then loaded into the result register; a clear
// also blanks every cell first. A write that scrolls copies one cell per cycle through
// the single read and single write port of the screen memory, then blanks the bottom row.
// One item is in work at a time; the next is accepted in the cycle after the result is loaded
// into the output register.
// After reset the screen memory is blanked with req_ready low.
module text_console_writer_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tcw_pkg::OP_W-1:0]    req_opcode,
   input  logic [tcw_pkg::CHAR_W-1:0]  req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]   req_read_row,
   input  logic [tcw_pkg::COL_W-1:0]   req_read_col,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tcw_pkg::CHAR_W-1:0]  rsp_cell_char,
   output logic [tcw_pkg::COL_W-1:0]   rsp_cursor_col,
   output logic [tcw_pkg::ROW_W-1:0]   rsp_cursor_row,
   output logic                        rsp_scrolled
);
   import tcw_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencing of each item.
   tcw_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Cursor, screen memory and result register.
   tcw_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_opcode),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_scrolled   (rsp_scrolled)
   );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the text console core: a directed table, then random console traffic.
module tb;
   import tcw_pkg::*;

   // The fourth opcode has no name in the package; it must leave everything unchanged.
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   localparam int NUM_DIRECTED   = 22;
   localparam int RANDOM_ITEMS   = 280;
   localparam int NUM_PHASES     = 4;
   localparam int RX_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES    = 16;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [CHAR_W-1:0] char_code;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_col;
   } console_req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] cell_char;
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
      logic              scrolled;
   } console_rsp_type;

   // One row of the directed table; known marks a result typed in by hand.
   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [CHAR_W-1:0] char_code;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_col;
      logic              known;
      logic [CHAR_W-1:0] exp_char;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic              scr;
   } directed_row_type;

   directed_row_type directed_table [NUM_DIRECTED] = '{
      // Fresh screen reads as spaces, corners included.
      '{OP_READ,  8'h00,      5'd0,  7'd0,   1'b1, CH_SPACE, 7'd0, 5'd0, 1'b0},
      '{OP_READ,  8'hFF,      5'd24, 7'd79,  1'b1, CH_SPACE, 7'd0, 5'd0, 1'b0},
      // Reads outside the screen return zero.
      '{OP_READ,  8'h00,      5'd25, 7'd0,   1'b1, 8'h00,    7'd0, 5'd0, 1'b0},
      '{OP_READ,  8'h00,      5'd0,  7'd80,  1'b1, 8'h00,    7'd0, 5'd0, 1'b0},
      '{OP_READ,  8'h00,      5'd31, 7'd127, 1'b1, 8'h00,    7'd0, 5'd0, 1'b0},
      // Byte extremes are stored as they are.
      '{OP_WRITE, 8'h00,      5'd31, 7'd127, 1'b1, 8'h00,    7'd1, 5'd0, 1'b0},
      '{OP_WRITE, 8'hFF,      5'd0,  7'd0,   1'b1, 8'h00,    7'd2, 5'd0, 1'b0},
      '{OP_WRITE, 8'h41,      5'd17, 7'd99,  1'b0, 8'h00,    7'd0, 5'd0, 1'b0},
      '{OP_WRITE, CH_SPACE,   5'd0,  7'd0,   1'b0, 8'h00,    7'd0, 5'd0, 1'b0},
      '{OP_READ,  8'hFF,      5'd0,  7'd0,   1'b0, 8'h00,    7'd0, 5'd0, 1'b0},
      '{OP_READ,  8'h00,      5'd0,  7'd1,   1'b0, 8'h00,    7'd0, 5'd0, 1'b0},
      // Carriage return, then overwrite column zero, then newline.
      '{OP_WRITE, CH_RETURN,  5'd0,  7'd0,   1'b1, 8'h00,    7'd0, 5'd0, 1'b0},
      '{OP_WRITE, 8'h7E,      5'd0,  7'd0,   1'b0, 8'h00,    7'd0, 5'd0, 1'b0},
      '{OP_WRITE, CH_NEWLINE, 5'd0,  7'd0,   1'b1, 8'h00,    7'd0, 5'd1, 1'b0},
      // The unused opcode changes nothing.
      '{OP_NONE,  8'hFF,      5'd31, 7'd127, 1'b1, 8'h00,    7'd0, 5'd1, 1'b0},
      '{OP_READ,  8'h00,      5'd0,  7'd0,   1'b0, 8'h00,    7'd0, 5'd0, 1'b0},
      // Clear blanks the screen and keeps the cursor.
      '{OP_CLEAR, 8'hFF,      5'd31, 7'd127, 1'b1, 8'h00,    7'd0, 5'd1, 1'b0},
      '{OP_READ,  8'h00,      5'd0,  7'd0,   1'b1, CH_SPACE, 7'd0, 5'd1, 1'b0},
      '{OP_WRITE, 8'h80,      5'd0,  7'd0,   1'b0, 8'h00,    7'd0, 5'd0, 1'b0},
      '{OP_READ,  8'hFF,      5'd1,  7'd0,   1'b0, 8'h00,    7'd0, 5'd0, 1'b0},
      '{OP_READ,  8'h00,      5'd1,  7'd79,  1'b0, 8'h00,    7'd0, 5'd0, 1'b0},
      '{OP_WRITE, CH_NEWLINE, 5'd0,  7'd0,   1'b0, 8'h00,    7'd0, 5'd0, 1'b0}
   };

   int tx_idle_by_phase  [NUM_PHASES] = '{0, 88, 0, 32};
   int rx_stall_by_phase [NUM_PHASES] = '{0, 0, 88, 32};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [OP_W-1:0]   req_opcode = '0;
   logic [CHAR_W-1:0] req_char_code = '0;
   logic [ROW_W-1:0]  req_read_row = '0;
   logic [COL_W-1:0]  req_read_col = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CHAR_W-1:0] rsp_cell_char;
   logic [COL_W-1:0]  rsp_cursor_col;
   logic [ROW_W-1:0]  rsp_cursor_row;
   logic              rsp_scrolled;

   // Console image and cursor as the predictor sees them.
   logic [CHAR_W-1:0] screen_mem [ROWS][COLUMNS];
   int cur_col;
   int cur_row;

   console_rsp_type expected_rsp_q [$];
   int error_count  = 0;
   int items_sent   = 0;
   int results_seen = 0;
   int scroll_cnt   = 0;
   int wrap_cnt     = 0;
   int clear_cnt    = 0;
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;
   int hold_req_cnt = 0;

   text_console_writer_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_scrolled   (rsp_scrolled)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Fill the whole console image with spaces.
   function automatic void blank_screen();
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLUMNS; c++) begin
            screen_mem[r][c] = CH_SPACE;
         end
      end
   endfunction

   // Apply one item to the console image and return the result it must produce.
   function automatic console_rsp_type console_step(input console_req_type it);
      console_rsp_type res;
      res = '0;
      case (it.opcode)
         OP_WRITE: begin
            if (it.char_code == CH_NEWLINE) begin
               cur_col = 0;
               cur_row++;
            end else if (it.char_code == CH_RETURN) begin
               cur_col = 0;
            end else begin
               screen_mem[cur_row][cur_col] = it.char_code;
               cur_col++;
            end
            if (cur_col >= COLUMNS) begin
               cur_col = 0;
               cur_row++;
               wrap_cnt++;
            end
            // Past the bottom row: move every row up and blank the last one.
            if (cur_row >= ROWS) begin
               for (int r = 0; r < ROWS - 1; r++) begin
                  for (int c = 0; c < COLUMNS; c++) begin
                     screen_mem[r][c] = screen_mem[r + 1][c];
                  end
               end
               for (int c = 0; c < COLUMNS; c++) begin
                  screen_mem[ROWS - 1][c] = CH_SPACE;
               end
               cur_row = ROWS - 1;
               res.scrolled = 1'b1;
               scroll_cnt++;
            end
         end
         OP_READ: begin
            if (it.read_row < ROWS && it.read_col < COLUMNS) begin
               res.cell_char = screen_mem[it.read_row][it.read_col];
            end
         end
         OP_CLEAR: begin
            blank_screen();
            clear_cnt++;
         end
         default: begin
         end
      endcase
      res.cursor_col = cur_col[COL_W-1:0];
      res.cursor_row = cur_row[ROW_W-1:0];
      return res;
   endfunction

   // Offer one item after a random idle gap, wait for its transfer and record the expectation.
   task automatic send_item(input console_req_type it, input bit use_typed,
                            input console_rsp_type typed);
      console_rsp_type predicted;
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= it.opcode;
      req_char_code <= it.char_code;
      req_read_row  <= it.read_row;
      req_read_col  <= it.read_col;
      do @(posedge clock); while (!req_ready);
      predicted = console_step(it);
      expected_rsp_q.push_back(use_typed ? typed : predicted);
      items_sent++;
   endtask

   task automatic send_write(input logic [CHAR_W-1:0] ch);
      console_req_type it;
      it.opcode    = OP_WRITE;
      it.char_code = ch;
      it.read_row  = ROW_W'($urandom_range(31));
      it.read_col  = COL_W'($urandom_range(127));
      send_item(it, 1'b0, '0);
   endtask

   task automatic send_read(input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
      console_req_type it;
      it.opcode    = OP_READ;
      it.char_code = CHAR_W'($urandom_range(255));
      it.read_row  = rr;
      it.read_col  = rc;
      send_item(it, 1'b0, '0);
   endtask

   // A line at least as long as the screen width, so the cursor wraps at least once.
   task automatic long_line();
      logic [CHAR_W-1:0] ch;
      int n;
      n = $urandom_range(COLUMNS + 10, COLUMNS);
      repeat (n) begin
         ch = CHAR_W'($urandom_range(255));
         if (ch == CH_NEWLINE || ch == CH_RETURN) ch = CH_SPACE;
         send_write(ch);
      end
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp_q.size() != 0);
   endtask

   function automatic void check_field(input string what, input int expv, input int actv);
      if (expv != actv) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, expv, actv);
         error_count++;
      end
   endfunction

   // Result side: random stalls, the long hold-off, and the check of every transfer.
   always @(posedge clock) begin : result_side
      console_rsp_type exp_rsp;
      int hold_left;
      int hold_seen;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         hold_seen = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_rsp_q.size() == 0) begin
               $display("%0t ns: result with none expected, actual char %0d col %0d row %0d",
                        $time, rsp_cell_char, rsp_cursor_col, rsp_cursor_row);
               error_count++;
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               check_field("cell_char", int'(exp_rsp.cell_char), int'(rsp_cell_char));
               check_field("cursor_col", int'(exp_rsp.cursor_col), int'(rsp_cursor_col));
               check_field("cursor_row", int'(exp_rsp.cursor_row), int'(rsp_cursor_row));
               check_field("scrolled", int'(exp_rsp.scrolled), int'(rsp_scrolled));
            end
         end
         if (hold_seen != hold_req_cnt) begin
            hold_seen = hold_req_cnt;
            hold_left = RX_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   // Watchdog: too long without any transfer on either side ends the run.
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, expected_rsp_q.size());
            $display("** text_console_writer_core: FAILED **");
            $finish;
         end
      end
   end

   initial begin : stimulus
      console_req_type it;
      console_rsp_type typed;
      int phase_start;
      int kind;
      int n;
      bit hold_done;
      hold_done = 1'b0;
      blank_screen();
      cur_col = 0;
      cur_row = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed table, no idling.
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         it    = '{directed_table[i].opcode, directed_table[i].char_code,
                   directed_table[i].read_row, directed_table[i].read_col};
         typed = '{directed_table[i].exp_char, directed_table[i].col,
                   directed_table[i].row, directed_table[i].scr};
         send_item(it, directed_table[i].known, typed);
      end
      wait_drained();

      // Random console traffic under each idle and stall pattern.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         tx_idle_pct  = tx_idle_by_phase[phase];
         rx_stall_pct = rx_stall_by_phase[phase];
         phase_start  = items_sent;
         if (phase == 1) long_line();
         while (items_sent - phase_start < RANDOM_ITEMS / NUM_PHASES) begin
            // Hold the result side off while items keep coming, so the core backs up.
            if (phase == 0 && !hold_done && items_sent - phase_start >= 10) begin
               hold_req_cnt++;
               hold_done = 1'b1;
            end
            kind = $urandom_range(99);
            if (kind < 40) begin
               // A short line of text ended by newline or carriage return.
               n = $urandom_range(12);
               repeat (n) send_write(CHAR_W'($urandom_range(255)));
               send_write(($urandom_range(99) < 70) ? CH_NEWLINE : CH_RETURN);
            end else if (kind < 62) begin
               // Reads, mostly on the screen and often on the cursor row.
               n = $urandom_range(4, 1);
               repeat (n) begin
                  if ($urandom_range(9) < 8) begin
                     send_read($urandom_range(1) ? ROW_W'(cur_row)
                                                 : ROW_W'($urandom_range(ROWS - 1)),
                               COL_W'($urandom_range(COLUMNS - 1)));
                  end else begin
                     send_read(ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
                  end
               end
            end else if (kind < 65) begin
               long_line();
            end else if (kind < 75) begin
               n = $urandom_range(3, 1);
               repeat (n) send_write(CH_NEWLINE);
            end else if (kind < 78) begin
               it = '{OP_CLEAR, CHAR_W'($urandom_range(255)), ROW_W'($urandom_range(31)),
                      COL_W'($urandom_range(127))};
               send_item(it, 1'b0, '0);
            end else begin
               // Noise: any opcode with any field values.
               it = '{OP_W'($urandom_range(3)), CHAR_W'($urandom_range(255)),
                      ROW_W'($urandom_range(31)), COL_W'($urandom_range(127))};
               send_item(it, 1'b0, '0);
            end
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d items (%0d from the directed table) and checked %0d results.",
               items_sent, NUM_DIRECTED, results_seen);
      $display("The run saw %0d scrolls, %0d line wraps and %0d clears under four idle patterns.",
               scroll_cnt, wrap_cnt, clear_cnt);
      if (error_count == 0) begin
         $display("** text_console_writer_core: PASSED **");
      end else begin
         $display("** text_console_writer_core: FAILED **");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_datapath.sv
rtl/core/tcw_controller.sv
rtl/core/text_console_writer_core.sv
tb/sv/tb.sv
